/* hdl/rcmt_pkg.sv */
// rcmt_pkg: shared types and constants of the rms current monitor
// action and result codes, field widths, queue job format, back-end states
// no dependencies
package rcmt_pkg;

    localparam int ADC_BITS    = 12;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 14;
    localparam int ZC_W        = 13;
    localparam int WIN_W       = 4;
    localparam int CORR_BITS   = ADC_BITS + 2;
    localparam int CORR_LIMIT  = (1 << CORR_BITS) - 1;
    localparam int TRIP_W      = CORR_BITS;
    localparam int MEAN_W      = 2 * CORR_BITS;
    localparam int ROOT_W      = CORR_BITS;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 32;
    localparam int USER_W      = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [WIN_W-1:0]  WINDOW_LOG2_RST = WIN_W'(8);
    localparam logic [GAIN_W-1:0] GAIN_RST        = GAIN_W'(16384);
    localparam logic [TRIP_W-1:0] TRIP_LEVEL_RST  = TRIP_W'(16383);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_LOG2,
        REG_GAIN,
        REG_ZERO_CORR,
        REG_TRIP_LEVEL
    } cfg_reg_t;

    typedef enum logic [USER_W-1:0] {
        ACT_CAL,
        ACT_MEAS,
        ACT_SWITCH,
        ACT_NONE
    } action_t;

    typedef enum logic [USER_W-1:0] {
        KIND_CAL,
        KIND_RMS,
        KIND_SWITCH
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic                 toggle;
        logic [MEAN_W-1:0]    mean;
        logic [ADC_BITS-1:0]  offset;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_OUT
    } back_state_t;

endpackage

/* hdl/rms_current_monitor_trip.sv */
// rms_current_monitor_trip: windowed rms over-current monitor, top level
// a window-ending sample passes the 3-stage front pipeline and the job queue; the back end
// then loads the job and, for an rms result, runs the bit-serial square root before output
// throughput: one sample per cycle while the 4-entry job queue has room; the back end
// takes one job at a time and pops the next only after the last result is accepted
// reset: asynchronous, clears control state and loads register defaults, no clearing pass
module rms_current_monitor_trip
    import rcmt_pkg::*;
#(
    parameter int MAX_WINDOW_LOG2 = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // sample[11:0], switch_level[12], zero pad
    input  logic [USER_W-1:0]      s_tuser,   // action[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // rms_value[13:0], offset_value[25:14],
                                              // tripped[26], running[27], zero pad
    output logic [USER_W-1:0]      m_tuser,   // kind[1:0]
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LG_W = $clog2(MAX_WINDOW_LOG2 + 1);

    logic [WIN_W-1:0]         window_log2_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [ZC_W-1:0]   zero_corr_reg;
    logic [TRIP_W-1:0]        trip_level_reg;
    logic [LG_W-1:0]          lg;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    job_t push_job;
    job_t head_job;

    assign lg = (int'(window_log2_reg) > MAX_WINDOW_LOG2) ? LG_W'(MAX_WINDOW_LOG2)
                                                           : LG_W'(window_log2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_log2_reg <= WINDOW_LOG2_RST;
            gain_reg        <= GAIN_RST;
            zero_corr_reg   <= '0;
            trip_level_reg  <= TRIP_LEVEL_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WINDOW_LOG2: window_log2_reg <= cfg_data[WIN_W-1:0];
                REG_GAIN:        gain_reg        <= cfg_data[GAIN_W-1:0];
                REG_ZERO_CORR:   zero_corr_reg   <= $signed(cfg_data[ZC_W-1:0]);
                REG_TRIP_LEVEL:  trip_level_reg  <= cfg_data[TRIP_W-1:0];
            endcase
        end
    end

    rcmt_front #(
        .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .lg        (lg),
        .gain      (gain_reg),
        .zero_corr (zero_corr_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    rcmt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    rcmt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .trip_level (trip_level_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

/* hdl/rcmt_front.sv */
// rcmt_front: accepts samples, tracks windows and the stored offset,
// and runs the gain, correction and square pipeline into the job queue
// depends on rcmt_pkg
module rcmt_front
    import rcmt_pkg::*;
#(
    parameter int MAX_WINDOW_LOG2 = 10,
    localparam int LG_W = $clog2(MAX_WINDOW_LOG2 + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [IN_DATA_W-1:0]        s_tdata,
    input  logic [USER_W-1:0]           s_tuser,
    input  logic [LG_W-1:0]             lg,
    input  logic [GAIN_W-1:0]           gain,
    input  logic signed [ZC_W-1:0]      zero_corr,
    input  logic                        q_full,
    output logic                        q_push,
    output job_t                        q_job
);

    localparam int CNT_W    = MAX_WINDOW_LOG2 + 1;
    localparam int RAW_W    = ADC_BITS + MAX_WINDOW_LOG2;
    localparam int SQ_W     = MEAN_W + MAX_WINDOW_LOG2;
    localparam int PROD_W   = ADC_BITS + GAIN_W;
    localparam int SCALED_W = PROD_W + 1 - GAIN_FRAC;
    localparam int V_W      = CORR_BITS + 3;
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1 << (GAIN_FRAC - 1));

    typedef struct packed {
        kind_t               kind;
        logic                emit;
        logic                first;
        logic                toggle;
        logic [ADC_BITS-1:0] offset;
    } tag_t;

    action_t              act;
    logic [ADC_BITS-1:0]  smp;
    logic                 lvl;
    logic                 en;
    logic                 accept;

    action_t              last_action_reg, last_action_next;
    logic                 last_switch_reg, last_switch_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [RAW_W-1:0]     raw_sum_reg, raw_sum_next;
    logic [ADC_BITS-1:0]  offset_reg, offset_next;

    logic [CNT_W-1:0]     cnt_base;
    logic [CNT_W-1:0]     cnt_inc;
    logic [CNT_W-1:0]     win_size;
    logic                 win_end;
    logic                 first;
    logic [RAW_W-1:0]     raw_total;
    kind_t                item_kind;

    logic                 s1_valid_reg, s1_valid_next;
    tag_t                 s1_tag_reg, s1_tag_next;
    logic [PROD_W-1:0]    s1_prod_reg, s1_prod_next;
    logic                 s2_valid_reg;
    tag_t                 s2_tag_reg;
    logic [CORR_BITS-1:0] s2_mag_reg, s2_mag_next;
    logic                 s3_valid_reg;
    tag_t                 s3_tag_reg;
    logic [MEAN_W-1:0]    s3_sq_reg, s3_sq_next;
    logic [SQ_W-1:0]      sq_sum_reg, sq_sum_next;

    logic [PROD_W:0]        rounded;
    logic [SCALED_W-1:0]    scaled;
    logic signed [V_W-1:0]  v;
    logic [V_W-1:0]         v_abs;

    assign act    = action_t'(s_tuser);
    assign smp    = s_tdata[ADC_BITS-1:0];
    assign lvl    = s_tdata[ADC_BITS];
    assign en     = !(s3_valid_reg && s3_tag_reg.emit && q_full);
    assign accept = s_tvalid && en;
    assign s_tready = en;

    // window bookkeeping at accept
    assign cnt_base  = (act != last_action_reg) ? '0 : count_reg;
    assign cnt_inc   = cnt_base + CNT_W'(1);
    assign win_size  = CNT_W'(1) << lg;
    assign win_end   = cnt_inc >= win_size;
    assign first     = cnt_base == '0;
    assign raw_total = (first ? '0 : raw_sum_reg) + RAW_W'(smp);

    always_comb
    begin
        unique case (act)
            ACT_CAL:    item_kind = KIND_CAL;
            ACT_MEAS:   item_kind = KIND_RMS;
            ACT_SWITCH: item_kind = KIND_SWITCH;
            ACT_NONE:   item_kind = KIND_CAL;
        endcase
    end

    always_comb
    begin
        last_action_next = last_action_reg;
        last_switch_next = last_switch_reg;
        count_next       = count_reg;
        raw_sum_next     = raw_sum_reg;
        offset_next      = offset_reg;
        s1_valid_next    = 1'b0;
        if (accept && act != ACT_NONE)
        begin
            last_action_next = act;
            s1_valid_next    = 1'b1;
            unique case (act)
                ACT_CAL:
                begin
                    raw_sum_next = raw_total;
                    count_next   = win_end ? '0 : cnt_inc;
                    if (win_end)
                    begin
                        offset_next = ADC_BITS'(raw_total >> lg);
                    end
                end
                ACT_MEAS:
                begin
                    count_next = win_end ? '0 : cnt_inc;
                end
                ACT_SWITCH:
                begin
                    last_switch_next = lvl;
                    count_next       = '0;
                end
                ACT_NONE:
                begin
                end
            endcase
        end
        s1_tag_next.kind   = item_kind;
        s1_tag_next.emit   = (act == ACT_SWITCH) || win_end;
        s1_tag_next.first  = first;
        s1_tag_next.toggle = last_switch_reg && !lvl;
        s1_tag_next.offset = offset_next;
        s1_prod_next       = PROD_W'(smp) * PROD_W'(gain);
    end

    // gain rounding, correction, saturation and magnitude
    always_comb
    begin
        rounded = {1'b0, s1_prod_reg} + ROUND_HALF;
        scaled  = rounded[PROD_W:GAIN_FRAC];
        v = $signed({{(V_W - SCALED_W){1'b0}}, scaled}) - V_W'(zero_corr)
            - $signed({{(V_W - ADC_BITS){1'b0}}, s1_tag_reg.offset});
        v_abs = v[V_W-1] ? V_W'(-v) : V_W'(v);
        s2_mag_next = (v_abs > V_W'(CORR_LIMIT)) ? CORR_BITS'(CORR_LIMIT)
                                                 : v_abs[CORR_BITS-1:0];
    end

    assign s3_sq_next  = MEAN_W'(s2_mag_reg) * MEAN_W'(s2_mag_reg);
    assign sq_sum_next = (s3_tag_reg.first ? '0 : sq_sum_reg) + SQ_W'(s3_sq_reg);

    assign q_push        = en && s3_valid_reg && s3_tag_reg.emit;
    assign q_job.kind    = s3_tag_reg.kind;
    assign q_job.toggle  = s3_tag_reg.toggle;
    assign q_job.offset  = s3_tag_reg.offset;
    assign q_job.mean    = MEAN_W'(sq_sum_next >> lg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_action_reg <= ACT_CAL;
            last_switch_reg <= 1'b1;
            count_reg       <= '0;
            offset_reg      <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
        end
        else
        begin
            last_action_reg <= last_action_next;
            last_switch_reg <= last_switch_next;
            count_reg       <= count_next;
            offset_reg      <= offset_next;
            if (en)
            begin
                s1_valid_reg <= s1_valid_next;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raw_sum_reg <= raw_sum_next;
        if (en)
        begin
            s1_tag_reg  <= s1_tag_next;
            s1_prod_reg <= s1_prod_next;
            s2_tag_reg  <= s1_tag_reg;
            s2_mag_reg  <= s2_mag_next;
            s3_tag_reg  <= s2_tag_reg;
            s3_sq_reg   <= s3_sq_next;
            if (s3_valid_reg && s3_tag_reg.kind == KIND_RMS)
            begin
                sq_sum_reg <= sq_sum_next;
            end
        end
    end

endmodule

/* hdl/rcmt_queue.sv */
// rcmt_queue: short job queue between the front pipeline and the back end
// depends on rcmt_pkg
module rcmt_queue
    import rcmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic full,
    output logic empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    job_t             slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign full     = fill_reg == CNT_W'(QUEUE_DEPTH);
    assign empty    = fill_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hdl/rcmt_back.sv */
// rcmt_back: takes jobs from the queue, runs the bit-serial square root,
// applies trip and switch toggles to the run flag and holds the result
// depends on rcmt_pkg
module rcmt_back
    import rcmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  job_t                  head_job,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  logic [TRIP_W-1:0]     trip_level,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [USER_W-1:0]     m_tuser
);

    localparam int REM_W  = ROOT_W + 3;
    localparam int STEP_W = $clog2(ROOT_W);
    localparam int PAD_W  = OUT_DATA_W - ROOT_W - ADC_BITS - 2;

    back_state_t         state_reg, state_next;
    logic [MEAN_W-1:0]   val_reg, val_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    kind_t               kind_reg, kind_next;
    logic [ROOT_W-1:0]   rms_reg, rms_next;
    logic [ADC_BITS-1:0] offset_reg, offset_next;
    logic                tripped_reg, tripped_next;
    logic                run_reg, run_next;

    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;
    logic                ge;
    logic [REM_W-1:0]    rem_it;
    logic [ROOT_W-1:0]   root_it;

    // one root bit per cycle
    assign rem_sh  = {rem_reg[REM_W-3:0], val_reg[MEAN_W-1 -: 2]};
    assign trial   = REM_W'({root_reg, 2'b01});
    assign ge      = rem_sh >= trial;
    assign rem_it  = ge ? rem_sh - trial : rem_sh;
    assign root_it = {root_reg[ROOT_W-2:0], ge};

    always_comb
    begin
        state_next   = state_reg;
        val_next     = val_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        step_next    = step_reg;
        kind_next    = kind_reg;
        rms_next     = rms_reg;
        offset_next  = offset_reg;
        tripped_next = tripped_reg;
        run_next     = run_reg;
        q_pop        = 1'b0;
        m_tvalid     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    kind_next    = head_job.kind;
                    offset_next  = head_job.offset;
                    rms_next     = '0;
                    tripped_next = 1'b0;
                    if (head_job.kind == KIND_RMS)
                    begin
                        val_next   = head_job.mean;
                        rem_next   = '0;
                        root_next  = '0;
                        step_next  = STEP_W'(ROOT_W - 1);
                        state_next = ST_ROOT;
                    end
                    else
                    begin
                        if (head_job.kind == KIND_SWITCH)
                        begin
                            run_next = run_reg ^ head_job.toggle;
                        end
                        state_next = ST_OUT;
                    end
                end
            end
            ST_ROOT:
            begin
                val_next  = val_reg << 2;
                rem_next  = rem_it;
                root_next = root_it;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    rms_next     = root_it;
                    tripped_next = root_it > trip_level;
                    if (root_it > trip_level)
                    begin
                        run_next = 1'b0;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tdata = {{PAD_W{1'b0}}, run_reg, tripped_reg, offset_reg, rms_reg};
    assign m_tuser = kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            run_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        step_reg    <= step_next;
        kind_reg    <= kind_next;
        rms_reg     <= rms_next;
        offset_reg  <= offset_next;
        tripped_reg <= tripped_next;
    end

endmodule

/* hdl/rcmt_checker.sv */
// rcmt_checker: port-level assertions for the rms current monitor
// depends on rcmt_pkg, bound to rms_current_monitor_trip
module rcmt_checker
    import rcmt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_DATA_W-1:0]  m_tdata,
    input logic [USER_W-1:0]      m_tuser
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // only rms results carry a root or a trip
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_RMS |-> m_tdata[ROOT_W-1:0] == '0 && !m_tdata[26])
        else $error("non-rms result carries rms data");

    // a trip always stops the run flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[26] |-> !m_tdata[27])
        else $error("tripped result still running");

    // a trip needs a nonzero root
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[26] |-> m_tdata[ROOT_W-1:0] != '0)
        else $error("trip with zero rms");

endmodule

bind rms_current_monitor_trip rcmt_checker u_rcmt_checker (.*);
